// ===== hw/rtl/kmp_pkg.sv =====
// kmp_pkg: shared types and constants for the byte pattern search block
// no dependencies; imported by the top level

package kmp_pkg;

   // default sizes, handed to the top level parameters
   localparam int PATTERN_MAX_DEF = 512;
   localparam int OFFSET_BITS_DEF = 32;

   // reported offset width and its saturation value
   localparam int             OUT_W   = 32;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   // item operation codes
   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BUILD  = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/kmp_pat_mem.sv =====
// kmp_pat_mem: pattern byte store and failure table, one write and one read port each
// registered read data; no package dependencies

module kmp_pat_mem #(
   parameter int PAT_DEPTH = 512,
   parameter int ADDR_W    = 9,
   parameter int LEN_W     = 10
) (
   input  logic              clock,
   input  logic              pat_we,
   input  logic [ADDR_W-1:0] pat_waddr,
   input  logic [7:0]        pat_wdata,
   input  logic [ADDR_W-1:0] pat_raddr,
   output logic [7:0]        pat_rdata,
   input  logic              fail_we,
   input  logic [LEN_W-1:0]  fail_waddr,
   input  logic [LEN_W-1:0]  fail_wdata,
   input  logic [LEN_W-1:0]  fail_raddr,
   output logic [LEN_W-1:0]  fail_rdata
);

   logic [7:0]       pat_mem [PAT_DEPTH];
   logic [LEN_W-1:0] fail_mem [PAT_DEPTH+1];
   logic [7:0]       pat_rdata_ff;
   logic [LEN_W-1:0] fail_rdata_ff;

   // pattern store port
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= pat_wdata;
      end
      pat_rdata_ff <= pat_mem[pat_raddr];
   end

   // failure table port
   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wdata;
      end
      fail_rdata_ff <= fail_mem[fail_raddr];
   end

   assign pat_rdata  = pat_rdata_ff;
   assign fail_rdata = fail_rdata_ff;

endmodule

// ===== hw/rtl/kmp_byte_pattern_search_top.sv =====
// kmp_byte_pattern_search_top: online failure-table build and byte stream search
// depends on kmp_pkg and kmp_pat_mem

// Usage: an item is taken when start is high and busy is low. Clear, restart and
// text bytes that arrive after the search has ended are handled in the idle
// state. An append or a live text byte needs k >= 1 failure-chain steps; each
// step is one read of the pattern store and failure table plus one byte compare.
// A text byte that ends the search (full match or last byte) passes through the
// report state to form the offset, and its result appears with rsp_valid high
// for exactly one cycle after that. The receiver cannot stall: results must be
// taken when shown. A new item may be accepted in the same cycle that a result
// is shown.

module kmp_byte_pattern_search_top
   import kmp_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_byte_value,
   input  logic             req_last_byte,
   output logic             busy,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic             rsp_done_res,
   output logic [OUT_W-1:0] rsp_match_offset
);

   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int ADDR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int WIDE_W = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;
   localparam logic [LEN_W-1:0]       LEN_FULL = LEN_W'(PATTERN_MAX);
   localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [LEN_W-1:0]       border_ff, border_in;
   logic [LEN_W-1:0]       matched_ff, matched_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   finished_ff, finished_in;
   logic [LEN_W-1:0]       m_ff, m_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic                   hit_ff, hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [OUT_W-1:0]       rsp_offset_ff, rsp_offset_in;

   op_type                 op;
   logic                   pat_we, fail_we;
   logic [7:0]             pat_rdata;
   logic [LEN_W-1:0]       fail_rdata;
   logic                   step_match, step_end;
   logic [LEN_W-1:0]       step_next;
   logic [WIDE_W-1:0]      pos_wide, len_wide, diff_wide, off_wide;
   logic [OUT_W-1:0]       off_sat;

   assign op = op_type'(req_op);

   // pattern store and failure table
   kmp_pat_mem #(
      .PAT_DEPTH (PATTERN_MAX),
      .ADDR_W    (ADDR_W),
      .LEN_W     (LEN_W)
   ) u_mem (
      .clock      (clock),
      .pat_we     (pat_we),
      .pat_waddr  (len_ff[ADDR_W-1:0]),
      .pat_wdata  (byte_ff),
      .pat_raddr  (m_in[ADDR_W-1:0]),
      .pat_rdata  (pat_rdata),
      .fail_we    (fail_we),
      .fail_waddr (len_ff + LEN_W'(1)),
      .fail_wdata (step_next),
      .fail_raddr (m_in),
      .fail_rdata (fail_rdata)
   );

   // shared step unit: compare one pattern byte, else follow the failure link
   always_comb begin
      step_match = (m_ff < len_ff) && (pat_rdata == byte_ff);
      step_end   = step_match || (m_ff == '0);
      if (step_match) begin
         step_next = m_ff + LEN_W'(1);
      end else if (m_ff != '0) begin
         step_next = fail_rdata;
      end else begin
         step_next = '0;
      end
   end

   // reported offset with saturation
   always_comb begin
      pos_wide  = WIDE_W'(pos_ff);
      len_wide  = WIDE_W'(len_ff);
      diff_wide = (pos_wide >= len_wide) ? (pos_wide - len_wide) : '0;
      off_wide  = hit_ff ? diff_wide : pos_wide;
      off_sat   = (off_wide > WIDE_W'(OUT_MAX)) ? OUT_MAX : off_wide[OUT_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      border_in     = border_ff;
      matched_in    = matched_ff;
      pos_in        = pos_ff;
      finished_in   = finished_ff;
      m_in          = m_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      pat_we        = 1'b0;
      fail_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               byte_in = req_byte_value;
               last_in = req_last_byte;
               case (op)
                  OP_CLEAR: begin
                     len_in      = '0;
                     border_in   = '0;
                     matched_in  = '0;
                     pos_in      = '0;
                     finished_in = 1'b0;
                  end
                  OP_APPEND: begin
                     if (len_ff != LEN_FULL) begin
                        m_in     = border_ff;
                        state_in = ST_BUILD;
                     end
                  end
                  OP_TEXT: begin
                     if (!finished_ff) begin
                        if (pos_ff != POS_MAX) begin
                           pos_in = pos_ff + OFFSET_BITS'(1);
                        end
                        m_in     = matched_ff;
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_RESTART: begin
                     matched_in  = '0;
                     pos_in      = '0;
                     finished_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_BUILD: begin
            m_in = step_next;
            if (step_end) begin
               pat_we    = 1'b1;
               fail_we   = 1'b1;
               border_in = step_next;
               len_in    = len_ff + LEN_W'(1);
               state_in  = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            m_in = step_next;
            if (step_end) begin
               matched_in = step_next;
               hit_in     = step_match && (step_next == len_ff);
               if ((step_match && (step_next == len_ff)) || last_ff) begin
                  finished_in = 1'b1;
                  state_in    = ST_REPORT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPORT: begin
            rsp_valid_in  = 1'b1;
            rsp_found_in  = hit_ff;
            rsp_offset_in = off_sat;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         border_ff    <= '0;
         matched_ff   <= '0;
         pos_ff       <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         border_ff    <= border_in;
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      hit_ff        <= hit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_done_res     = rsp_valid_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("pattern length beyond capacity");

   a_border_below_len: assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0) || (border_ff < len_ff))
      else $error("border not shorter than pattern");

   a_matched_below_len: assert property (@(posedge clock) disable iff (reset)
      (!finished_ff && (len_ff != '0)) |-> (matched_ff < len_ff))
      else $error("live search holds a complete match");

   a_report_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |=> (rsp_valid && !busy))
      else $error("report cycle did not produce a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule
